// ===== src/icymd_pkg.sv =====
// shared types and constants for the icy metadata demultiplexer
`timescale 1ns / 1ps

package icymd_pkg;

  localparam int unsigned CountW    = 20;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned MetaShift = 4;  // length byte counts units of 16 bytes

  typedef logic [CountW-1:0] count_t;
  typedef logic [ByteW-1:0]  byte_t;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_AUDIO = 4'b0010,
    PH_METAB = 4'b0100,
    PH_META  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic  emit;
    byte_t data;
    logic  is_meta;
    logic  last;
  } result_t;

endpackage

// ===== src/icymd_framer.sv =====
// framing state: phase and byte count, decides tag and last flag per byte
`timescale 1ns / 1ps

module icymd_framer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  icymd_pkg::byte_t data_byte,
  input  logic             chunk_end,
  input  icymd_pkg::count_t meta_interval,
  output icymd_pkg::result_t res
);
  import icymd_pkg::*;

  phase_t phase_r, phase_nxt;
  count_t left_r, left_nxt;

  phase_t eff_phase;
  count_t eff_left;
  logic   done;
  count_t left_dec;

  always_comb begin
    // first byte after start loads the interval and counts as audio
    if (phase_r == PH_START) begin
      eff_phase = PH_AUDIO;
      eff_left  = meta_interval;
    end else begin
      eff_phase = phase_r;
      eff_left  = left_r;
    end
    done     = (eff_left <= count_t'(1));
    left_dec = eff_left - count_t'(1);

    phase_nxt   = phase_r;
    left_nxt    = left_r;
    res.emit    = 1'b0;
    res.data    = data_byte;
    res.is_meta = 1'b0;
    res.last    = chunk_end;

    if (meta_interval == '0) begin
      // plain pass-through, framing restarts when enabled again
      phase_nxt = PH_START;
      left_nxt  = '0;
      res.emit  = 1'b1;
    end else begin
      unique case (eff_phase)
        PH_METAB: begin
          if (data_byte == '0) begin
            phase_nxt = PH_AUDIO;
            left_nxt  = meta_interval;
          end else begin
            phase_nxt = PH_META;
            left_nxt  = count_t'({data_byte, {MetaShift{1'b0}}});
          end
        end
        PH_META: begin
          res.emit    = 1'b1;
          res.is_meta = 1'b1;
          res.last    = done | chunk_end;
          if (done) begin
            phase_nxt = PH_AUDIO;
            left_nxt  = meta_interval;
          end else begin
            phase_nxt = PH_META;
            left_nxt  = left_dec;
          end
        end
        default: begin
          res.emit = 1'b1;
          res.last = done | chunk_end;
          if (done) begin
            phase_nxt = PH_METAB;
            left_nxt  = count_t'(1);
          end else begin
            phase_nxt = PH_AUDIO;
            left_nxt  = left_dec;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      left_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ===== src/icymd_out_reg.sv =====
// result register between the framer and the output channel
`timescale 1ns / 1ps

module icymd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  icymd_pkg::result_t res,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output icymd_pkg::byte_t   out_byte,
  output logic               out_is_meta,
  output logic               out_last
);
  import icymd_pkg::*;

  logic  valid_r, valid_nxt;
  byte_t data_r;
  logic  meta_r;
  logic  last_r;

  // full and held by the receiver: nothing can move in
  assign busy = valid_r & out_stall;

  always_comb begin
    valid_nxt = valid_r & out_stall;
    if (accept && res.emit) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.emit) begin
      data_r <= res.data;
      meta_r <= res.is_meta;
      last_r <= res.last;
    end
  end

  assign out_valid   = valid_r;
  assign out_byte    = data_r;
  assign out_is_meta = meta_r;
  assign out_last    = last_r;

endmodule

// ===== src/icy_metadata_demux_unit.sv =====
// top level of the icy stream metadata demultiplexer
`timescale 1ns / 1ps
//
// usage: stream body bytes go in on the in_ channel, one byte per transaction,
// with in_chunk_end marking the last byte of a received chunk. each byte that
// is not a metadata length byte comes out on the out_ channel tagged audio or
// meta, with out_last at the end of an audio interval, a metadata run or a chunk.
// cfg_meta_interval is written with cfg_wr_en while idle; zero means pass-through.
// a result shows on out_valid in the cycle after its byte is accepted.
// throughput: one byte per clock while in_stall is low; the framer state
// updates in the accept cycle and the single result register holds the output.
// in_stall rises only while the result register is full and out_stall is high;
// a stalled result holds its value until taken.
// length bytes are consumed without a result and leave the result register as is.
// reset: synchronous, active low; clears the interval to zero (pass-through),
// the framing phase to start and the result register to empty.
//

module icy_metadata_demux_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [19:0]            cfg_meta_interval,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  icymd_pkg::byte_t       in_data_byte,
  input  logic                   in_chunk_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output icymd_pkg::byte_t       out_byte,
  output logic                   out_is_meta,
  output logic                   out_last
);
  import icymd_pkg::*;

  count_t  interval_r;
  logic    accept;
  logic    busy;
  result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= '0;
    end else if (cfg_wr_en) begin
      interval_r <= cfg_meta_interval;
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid & ~busy;

  icymd_framer u_framer (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .chunk_end     (in_chunk_end),
    .meta_interval (interval_r),
    .res           (res)
  );

  icymd_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .res         (res),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_is_meta (out_is_meta),
    .out_last    (out_last)
  );

  // input only stalls behind a held result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held result");

  // pass-through mode always yields a result
  a_passthru_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && interval_r == '0) |=> out_valid)
    else $error("pass-through byte produced no result");

  // a length byte leaves no result behind
  a_length_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !res.emit && (!out_valid || !out_stall)) |=> !out_valid)
    else $error("result appeared for a length byte");

  // pass-through results are never tagged metadata
  a_passthru_audio: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && interval_r == '0) |=> !out_is_meta)
    else $error("pass-through byte tagged as metadata");

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the icy stream metadata demultiplexer with its own framing tracker
`timescale 1ns / 1ps

module testbench;
  import icymd_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned RandBytes  = 1850;
  localparam int unsigned PlanLen    = 16;
  localparam count_t      MaxInterval = 20'hFFFFF;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_AUDIO, CHK_META} row_chk_t;
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  typedef struct packed {
    row_kind_t kind;
    count_t    val;
    byte_t     b;
    logic      ce;
    logic [4:0] n;
    row_chk_t  chk;
    logic      last;
  } dir_row_t;

  typedef struct {
    int unsigned stamp;
    result_t     res;
  } exp_byte_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   cfg_wr_en = 1'b0;
  count_t cfg_meta_interval = '0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  byte_t  in_data_byte = '0;
  logic   in_chunk_end = 1'b0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  byte_t  out_byte;
  logic   out_is_meta;
  logic   out_last;

  icy_metadata_demux_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_meta_interval (cfg_meta_interval),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_chunk_end      (in_chunk_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_is_meta       (out_is_meta),
    .out_last          (out_last)
  );

  // framing tracker
  phase_t trk_phase = PH_START;
  count_t trk_left = '0;
  count_t trk_interval = '0;

  exp_byte_t exp_bytes [$];

  int unsigned cyc = 0;
  int unsigned n_in = 0, n_len = 0, n_out = 0, n_meta = 0, n_cfg = 0, n_mism = 0;
  int unsigned hold_asks = 0, holds_done = 0;
  int unsigned burst_left = 0;

  dir_row_t dir_rows [0:18] = '{
    '{ROW_BYTE, 20'd0, 8'h00, 1'b0, 5'd1, CHK_AUDIO, 1'b0},   // pass-through after reset
    '{ROW_BYTE, 20'd0, 8'hFF, 1'b1, 5'd1, CHK_AUDIO, 1'b1},
    '{ROW_CFG, 20'd1, 8'h00, 1'b0, 5'd0, CHK_PREDICT, 1'b0},
    '{ROW_BYTE, 20'd0, 8'h5A, 1'b1, 5'd1, CHK_AUDIO, 1'b1},   // first byte loads the interval
    '{ROW_BYTE, 20'd0, 8'h00, 1'b1, 5'd1, CHK_NONE, 1'b0},    // chunk end lost on length byte
    '{ROW_BYTE, 20'd0, 8'hA5, 1'b0, 5'd1, CHK_AUDIO, 1'b1},
    '{ROW_BYTE, 20'd0, 8'h01, 1'b0, 5'd1, CHK_NONE, 1'b0},    // one unit of metadata
    '{ROW_BYTE, 20'd0, 8'h10, 1'b0, 5'd14, CHK_PREDICT, 1'b0},
    '{ROW_BYTE, 20'd0, 8'hC3, 1'b1, 5'd1, CHK_META, 1'b1},    // chunk end inside the run
    '{ROW_BYTE, 20'd0, 8'h3C, 1'b0, 5'd1, CHK_META, 1'b1},
    '{ROW_CFG, MaxInterval, 8'h00, 1'b0, 5'd0, CHK_PREDICT, 1'b0},
    '{ROW_BYTE, 20'd0, 8'h77, 1'b0, 5'd1, CHK_AUDIO, 1'b1},   // old count still runs
    '{ROW_BYTE, 20'd0, 8'h00, 1'b0, 5'd1, CHK_NONE, 1'b0},
    '{ROW_BYTE, 20'd0, 8'h11, 1'b0, 5'd2, CHK_PREDICT, 1'b0},
    '{ROW_CFG, 20'd0, 8'h00, 1'b0, 5'd0, CHK_PREDICT, 1'b0},
    '{ROW_BYTE, 20'd0, 8'h99, 1'b0, 5'd1, CHK_AUDIO, 1'b0},   // framing dropped mid-interval
    '{ROW_CFG, 20'd2, 8'h00, 1'b0, 5'd0, CHK_PREDICT, 1'b0},
    '{ROW_BYTE, 20'd0, 8'h12, 1'b1, 5'd2, CHK_PREDICT, 1'b0},
    '{ROW_BYTE, 20'd0, 8'h00, 1'b0, 5'd1, CHK_NONE, 1'b0}
  };

  // the max interval is followed by zero so that framing restarts from a short count
  count_t interval_plan [0:PlanLen-1] = '{
    20'd5, 20'd1, 20'd2, 20'd0, 20'd3, 20'd31, 20'd1, MaxInterval,
    20'd0, 20'd6, 20'd2, 20'd64, 20'd0, 20'd4, 20'd1, 20'd9
  };

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  function automatic result_t split_byte(input byte_t b, input logic ce);
    result_t r;
    count_t len;
    logic done;
    r = '0;
    if (trk_interval == '0) begin
      trk_phase = PH_START;
      trk_left = '0;
      r.emit = 1'b1;
      r.data = b;
      r.last = ce;
      return r;
    end
    if (trk_phase == PH_START) begin
      trk_left = trk_interval;
      trk_phase = PH_AUDIO;
    end
    if (trk_phase == PH_METAB) begin
      len = count_t'(b) << MetaShift;
      if (len == '0) begin
        trk_left = trk_interval;
        trk_phase = PH_AUDIO;
      end else begin
        trk_left = len;
        trk_phase = PH_META;
      end
      return r;
    end
    done = (trk_left <= count_t'(1));
    trk_left = done ? '0 : trk_left - 1'b1;
    r.emit = 1'b1;
    r.data = b;
    r.last = done | ce;
    if (trk_phase == PH_META) begin
      r.is_meta = 1'b1;
      if (done) begin
        trk_left = trk_interval;
        trk_phase = PH_AUDIO;
      end
    end else if (done) begin
      trk_phase = PH_METAB;
      trk_left = count_t'(1);
    end
    return r;
  endfunction

  // length bytes are kept small so that framing turns over often
  function automatic byte_t pick_body_byte();
    int unsigned r;
    if (trk_interval == '0 || trk_phase != PH_METAB) return byte_t'($urandom_range(0, 255));
    r = $urandom_range(0, 999);
    if (r < 400) return 8'h00;
    if (r < 750) return 8'h01;
    if (r < 900) return byte_t'($urandom_range(2, 4));
    if (r < 995) return byte_t'($urandom_range(5, 15));
    return byte_t'($urandom_range(16, 255));
  endfunction

  task automatic offer(input byte_t b, input logic ce, input row_chk_t chk, input logic pin_last);
    result_t r;
    exp_byte_t e;
    int unsigned gap;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_chunk_end <= ce;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = split_byte(b, ce);
    if (chk != CHK_PREDICT) begin
      r.emit = (chk != CHK_NONE);
      r.data = b;
      r.is_meta = (chk == CHK_META);
      r.last = pin_last;
    end
    n_in++;
    if (r.emit) begin
      e.stamp = cyc;
      e.res = r;
      exp_bytes.push_back(e);
    end else begin
      n_len++;
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic set_interval(input count_t v);
    in_valid <= 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk);
    // idle wait before the write
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_meta_interval <= v;
    @(posedge clk);
    trk_interval = v;
    n_cfg++;
    cfg_wr_en <= 1'b0;
  endtask

  // result checker and watchdog
  always @(posedge clk) begin : check_out
    exp_byte_t e;
    if (cyc >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cyc, exp_bytes.size());
      $display("Verification failed");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      if (out_is_meta) n_meta++;
      if (exp_bytes.size() == 0 || exp_bytes[0].stamp >= cyc) begin
        n_mism++;
        if (n_mism <= 10)
          $display("unexpected transaction: byte %h meta %b last %b", out_byte, out_is_meta,
                   out_last);
      end else begin
        e = exp_bytes.pop_front();
        if (out_byte !== e.res.data || out_is_meta !== e.res.is_meta ||
            out_last !== e.res.last) begin
          n_mism++;
          if (n_mism <= 10)
            $display("result %0d: expected byte %h meta %b last %b, got %h meta %b last %b",
                     n_out, e.res.data, e.res.is_meta, e.res.last, out_byte, out_is_meta,
                     out_last);
        end
      end
    end
  end

  // receiver: stall pattern of its own, plus long hold-offs on request
  initial begin : rx_side
    rx_mode_t mode;
    int unsigned mode_left;
    mode = RX_FREE;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != holds_done) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        holds_done = holds_done + 1;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
          default:   out_stall <= ~out_stall;
        endcase
      end
    end
  end

  initial begin : tx_side
    int unsigned rand_in;
    int unsigned k;
    int unsigned n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        set_interval(dir_rows[i].val);
      end else begin
        for (int j = 0; j < dir_rows[i].n; j++)
          offer(byte_t'(dir_rows[i].b + j), dir_rows[i].ce, dir_rows[i].chk, dir_rows[i].last);
      end
    end

    rand_in = 0;
    k = 0;
    while (rand_in < RandBytes) begin
      set_interval(interval_plan[k % PlanLen]);
      if (k == 2 || k == 10) hold_asks <= hold_asks + 1;
      n = (interval_plan[k % PlanLen] == MaxInterval) ? $urandom_range(20, 40)
                                                     : $urandom_range(60, 170);
      repeat (n) offer(pick_body_byte(), ($urandom_range(0, 9) == 0), CHK_PREDICT, 1'b0);
      rand_in += n;
      k++;
    end

    in_valid <= 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d body bytes (%0d length bytes) over %0d interval settings",
             n_in, n_len, n_cfg);
    $display("checked %0d transactions, %0d metadata, %0d long receiver hold-offs",
             n_out, n_meta, holds_done);
    if (n_mism == 0 && exp_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never seen", n_mism, exp_bytes.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/icymd_pkg.sv
src/icymd_framer.sv
src/icymd_out_reg.sv
src/icy_metadata_demux_unit.sv
tb/sv/testbench.sv
